FILE: design/scl_pkg.sv
`default_nettype none

package scl_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int TARGET_W       = 16;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // literal lengths: "leftSpeed:" and ",rightSpeed:"
  localparam logic [3:0] LIT_FIRST_LEN  = 4'd10;
  localparam logic [3:0] LIT_SECOND_LEN = 4'd12;

  typedef enum logic [5:0] {
    PH_LITERAL = 6'b000001,
    PH_PRE     = 6'b000010,
    PH_SIGNED  = 6'b000100,
    PH_DIGITS  = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_FAIL    = 6'b100000
  } phase_t;

  // Character of the first (sel = 0) or second (sel = 1) literal.
  function automatic logic [7:0] lit_char(input logic sel, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (!sel) begin
      case (idx)
        4'd0:    ch = "l";
        4'd1:    ch = "e";
        4'd2:    ch = "f";
        4'd3:    ch = "t";
        4'd4:    ch = "S";
        4'd5:    ch = "p";
        4'd6:    ch = "e";
        4'd7:    ch = "e";
        4'd8:    ch = "d";
        4'd9:    ch = ":";
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    ch = ",";
        4'd1:    ch = "r";
        4'd2:    ch = "i";
        4'd3:    ch = "g";
        4'd4:    ch = "h";
        4'd5:    ch = "t";
        4'd6:    ch = "S";
        4'd7:    ch = "p";
        4'd8:    ch = "e";
        4'd9:    ch = "e";
        4'd10:   ch = "d";
        4'd11:   ch = ":";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: design/speed_command_line_parser_top.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_rx_byte [7:0]
// out     | output    | out_valid / out_ready | out_line_matched, out_left_target [15:0],
//         |           |                       | out_right_target [15:0] (signed)
//
// One byte per cycle while in_ready is high; the parse state advances in the cycle the byte transfers.
// A newline produces a registered result in the output register, or in the skid register if the output is stalled.
// A second result stage lets bytes keep flowing while the output is stalled;
// in_ready drops only when both result stages are full.
// rst_n (synchronous, active low) clears the parse state and the held speeds to zero.
`default_nettype none

module speed_command_line_parser_top
  import scl_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_line_matched,
  output logic signed [TARGET_W-1:0]      out_left_target,
  output logic signed [TARGET_W-1:0]      out_right_target
);

  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] MAG_CAP = {1'b1, {(VB-1){1'b0}}};

  // saturate the magnitude and apply the sign
  function automatic logic signed [VB-1:0] num_value(input logic [VB-1:0] mag,
                                                     input logic neg);
    logic [VB-1:0] m;
    if (neg) begin
      m = (mag > MAG_CAP) ? MAG_CAP : mag;
      m = -m;
    end else begin
      m = (mag > (MAG_CAP - 1'b1)) ? (MAG_CAP - 1'b1) : mag;
    end
    return signed'(m);
  endfunction

  phase_t                phase_r, phase_nxt;
  logic [3:0]            index_r, index_nxt;
  logic                  select_r, select_nxt;
  logic                  neg_r, neg_nxt;
  logic [VB-1:0]         acc_r, acc_nxt;
  logic signed [VB-1:0]  first_r, first_nxt;
  logic signed [VB-1:0]  held_left_r, held_right_r;

  logic                  out_valid_r, skid_valid_r;
  logic                  out_matched_r, skid_matched_r;
  logic signed [TARGET_W-1:0] out_left_r, out_right_r, skid_left_r, skid_right_r;

  logic                  in_fire, emit, out_load;
  logic                  is_space, is_digit, is_sign;
  logic                  restart_second, lit_step, lsel, lit_ok, lit_done;
  logic [3:0]            lidx, llen;
  logic [VB+3:0]         acc_ext, acc_sum;
  logic [VB-1:0]         acc_add;
  logic                  matched_new;
  logic signed [VB-1:0]  left_new, right_new;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign emit     = in_fire && (in_rx_byte == CH_NEWLINE);
  assign out_load = !out_valid_r || out_ready;

  assign is_space = (in_rx_byte == CH_SPACE) ||
                    ((in_rx_byte >= CH_TAB) && (in_rx_byte <= CH_CR));
  assign is_digit = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign is_sign  = (in_rx_byte == CH_PLUS) || (in_rx_byte == CH_MINUS);

  // accumulator * 10 + digit, capped at the largest negative magnitude
  assign acc_ext = {4'b0, acc_r};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{VB{1'b0}}, in_rx_byte[3:0]};
  assign acc_add = (acc_sum > {4'b0, MAG_CAP}) ? MAG_CAP : acc_sum[VB-1:0];

  // a non-digit after the first number restarts literal matching on the second literal
  assign restart_second = (phase_r == PH_DIGITS) && !is_digit && !select_r;
  assign lsel     = select_r || restart_second;
  assign lidx     = restart_second ? 4'd0 : index_r;
  assign llen     = lsel ? LIT_SECOND_LEN : LIT_FIRST_LEN;
  assign lit_ok   = (lidx < llen) && (in_rx_byte == lit_char(lsel, lidx));
  assign lit_done = (4'(lidx + 4'd1) == llen);

  always_comb begin
    phase_nxt  = phase_r;
    index_nxt  = index_r;
    select_nxt = select_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    lit_step   = 1'b0;
    unique case (phase_r) inside
      PH_LITERAL: begin
        lit_step = 1'b1;
      end
      PH_PRE: begin
        if (is_space) begin
          phase_nxt = PH_PRE;
        end else if (is_sign) begin
          neg_nxt   = (in_rx_byte == CH_MINUS);
          phase_nxt = PH_SIGNED;
        end else if (is_digit) begin
          acc_nxt   = acc_add;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_SIGNED: begin
        if (is_digit) begin
          acc_nxt   = acc_add;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_nxt = acc_add;
        end else if (!select_r) begin
          first_nxt  = num_value(acc_r, neg_r);
          select_nxt = 1'b1;
          index_nxt  = 4'd0;
          lit_step   = 1'b1;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE, PH_FAIL: begin
        phase_nxt = phase_r;
      end
      default: begin
        phase_nxt = PH_FAIL;
      end
    endcase
    if (lit_step) begin
      if (lit_ok) begin
        index_nxt = 4'(lidx + 4'd1);
        if (lit_done) begin
          phase_nxt = PH_PRE;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
        end else begin
          phase_nxt = PH_LITERAL;
        end
      end else begin
        phase_nxt = PH_FAIL;
      end
    end
  end

  assign matched_new = (phase_nxt == PH_DONE);
  assign left_new    = matched_new ? first_nxt : held_left_r;
  assign right_new   = matched_new ? num_value(acc_nxt, neg_nxt) : held_right_r;

  // parse state and held speeds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LITERAL;
      index_r      <= 4'd0;
      select_r     <= 1'b0;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      first_r      <= '0;
      held_left_r  <= '0;
      held_right_r <= '0;
    end else if (in_fire) begin
      if (emit) begin
        // end of line: return the parse state to its start
        phase_r      <= PH_LITERAL;
        index_r      <= 4'd0;
        select_r     <= 1'b0;
        neg_r        <= 1'b0;
        acc_r        <= '0;
        first_r      <= '0;
        held_left_r  <= left_new;
        held_right_r <= right_new;
      end else begin
        phase_r  <= phase_nxt;
        index_r  <= index_nxt;
        select_r <= select_nxt;
        neg_r    <= neg_nxt;
        acc_r    <= acc_nxt;
        first_r  <= first_nxt;
      end
    end
  end

  // result stages: output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emit;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_matched_r <= skid_matched_r;
        out_left_r    <= skid_left_r;
        out_right_r   <= skid_right_r;
      end else if (emit) begin
        out_matched_r <= matched_new;
        out_left_r    <= TARGET_W'(left_new);
        out_right_r   <= TARGET_W'(right_new);
      end
    end else if (emit) begin
      skid_matched_r <= matched_new;
      skid_left_r    <= TARGET_W'(left_new);
      skid_right_r   <= TARGET_W'(right_new);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_matched = out_matched_r;
  assign out_left_target  = out_left_r;
  assign out_right_target = out_right_r;

endmodule

`default_nettype wire

FILE: design/scl_checker.sv
`default_nettype none

module scl_checker
  import scl_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [7:0]                 in_rx_byte,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_line_matched,
  input wire logic signed [TARGET_W-1:0] out_left_target,
  input wire logic signed [TARGET_W-1:0] out_right_target
);

  logic [1:0]                 pending_r;
  logic signed [TARGET_W-1:0] last_left_r, last_right_r;
  logic                       nl_xfer, out_xfer;

  assign nl_xfer  = in_valid && in_ready && (in_rx_byte == CH_NEWLINE);
  assign out_xfer = out_valid && out_ready;

  // count lines accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= 2'd0;
      last_left_r  <= '0;
      last_right_r <= '0;
    end else begin
      pending_r <= 2'(pending_r + {1'b0, nl_xfer} - {1'b0, out_xfer});
      if (out_xfer) begin
        last_left_r  <= out_left_target;
        last_right_r <= out_right_target;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_matched) &&
      $stable(out_left_target) && $stable(out_right_target))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without a finished line");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> pending_r == 2'd2)
    else $error("input stalled with result storage free");

  a_keep_targets: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_line_matched |->
      out_left_target == last_left_r && out_right_target == last_right_r)
    else $error("targets changed on an unmatched line");

endmodule

bind speed_command_line_parser_top scl_checker u_scl_checker (.*);

`default_nettype wire
